[rtl/conic_type_classifier_top_defines.svh]
// assertion macros for the conic classifier rtl
// no dependencies; included by cct_classify, which checks its own pipeline logic
`ifndef CONIC_TYPE_CLASSIFIER_TOP_DEFINES_SVH
`define CONIC_TYPE_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define CCT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while reset is high
`define CCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cct_pkg.sv]
// shared widths, result codes and stage payload types of the conic classifier
// no dependencies; imported by the interfaces and every rtl module
package cct_pkg;

   localparam int COEF_BITS  = 16;
   localparam int KIND_BITS  = 4;
   localparam int I1_BITS    = COEF_BITS + 1;
   localparam int P2_BITS    = 2 * COEF_BITS;
   localparam int I2_BITS    = 2 * COEF_BITS + 3;
   localparam int K_BITS     = 2 * COEF_BITS + 4;
   localparam int P3_BITS    = 3 * COEF_BITS;
   localparam int PSUM_BITS  = 3 * COEF_BITS + 3;
   localparam int QSUM_BITS  = 3 * COEF_BITS + 2;
   localparam int I3_BITS    = 3 * COEF_BITS + 4;

   // curve kind codes
   typedef enum logic [KIND_BITS-1:0] {
      KIND_ELLIPSE        = 4'd0,
      KIND_HYPERBOLA      = 4'd1,
      KIND_PARABOLA       = 4'd2,
      KIND_IMAG_ELLIPSE   = 4'd3,
      KIND_POINT          = 4'd4,
      KIND_CROSS_LINES    = 4'd5,
      KIND_PARALLEL_LINES = 4'd6,
      KIND_LINE           = 4'd7,
      KIND_IMAG_PARALLEL  = 4'd8
   } kind_type;

   // sign of an invariant
   typedef struct packed {
      logic neg;
      logic zero;
   } sgn_type;

   // the six coefficients of one transaction
   typedef struct packed {
      logic signed [COEF_BITS-1:0] a;
      logic signed [COEF_BITS-1:0] b;
      logic signed [COEF_BITS-1:0] c;
      logic signed [COEF_BITS-1:0] d;
      logic signed [COEF_BITS-1:0] e;
      logic signed [COEF_BITS-1:0] f;
   } coef_type;

   // after the pairwise products
   typedef struct packed {
      logic signed [P2_BITS-1:0]   ac;
      logic signed [P2_BITS-1:0]   bb;
      logic signed [P2_BITS-1:0]   bd;
      logic signed [P2_BITS-1:0]   dd;
      logic signed [P2_BITS-1:0]   ee;
      logic signed [P2_BITS-1:0]   af;
      logic signed [P2_BITS-1:0]   cf;
      logic signed [COEF_BITS-1:0] a;
      logic signed [COEF_BITS-1:0] c;
      logic signed [COEF_BITS-1:0] e;
      logic signed [COEF_BITS-1:0] f;
      sgn_type                     sgn_i1;
   } pair_type;

   // after the triple products
   typedef struct packed {
      logic signed [P3_BITS-1:0] acf;
      logic signed [P3_BITS-1:0] bde;
      logic signed [P3_BITS-1:0] aee;
      logic signed [P3_BITS-1:0] cdd;
      logic signed [P3_BITS-1:0] fbb;
      sgn_type                   sgn_i1;
      sgn_type                   sgn_i2;
      sgn_type                   sgn_k;
   } triple_type;

   // determinant split into positive and negative partial sums
   typedef struct packed {
      logic signed [PSUM_BITS-1:0] p;
      logic signed [QSUM_BITS-1:0] q;
      sgn_type                     sgn_i1;
      sgn_type                     sgn_i2;
      sgn_type                     sgn_k;
   } part_type;

endpackage

[rtl/cct_if.sv]
// valid/ready channel interfaces for coefficient requests and kind responses
// depends on cct_pkg
interface cct_req_if import cct_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [COEF_BITS-1:0] coef_xx;
   logic signed [COEF_BITS-1:0] coef_xy;
   logic signed [COEF_BITS-1:0] coef_yy;
   logic signed [COEF_BITS-1:0] coef_x;
   logic signed [COEF_BITS-1:0] coef_y;
   logic signed [COEF_BITS-1:0] coef_const;

   modport source (output valid, coef_xx, coef_xy, coef_yy, coef_x, coef_y, coef_const,
                   input ready);
   modport sink   (input valid, coef_xx, coef_xy, coef_yy, coef_x, coef_y, coef_const,
                   output ready);
endinterface

interface cct_rsp_if import cct_pkg::*; ();
   logic     valid;
   logic     ready;
   kind_type curve_kind;

   modport source (output valid, curve_kind, input ready);
   modport sink   (input valid, curve_kind, output ready);
endinterface

[rtl/cct_pair_mul.sv]
// stage 1: pairwise coefficient products and the sign of a + c
// depends on cct_pkg
module cct_pair_mul import cct_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  coef_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output pair_type out_data
);

   logic                      valid_ff;
   pair_type                  data_ff;
   pair_type                  data_in;
   logic signed [I1_BITS-1:0] i1;

   // stage takes a transaction when empty or when it drains
   assign in_ready = !valid_ff || out_ready;

   // products and trace
   always_comb begin
      i1              = I1_BITS'(in_data.a) + I1_BITS'(in_data.c);
      data_in.ac      = P2_BITS'(in_data.a * in_data.c);
      data_in.bb      = P2_BITS'(in_data.b * in_data.b);
      data_in.bd      = P2_BITS'(in_data.b * in_data.d);
      data_in.dd      = P2_BITS'(in_data.d * in_data.d);
      data_in.ee      = P2_BITS'(in_data.e * in_data.e);
      data_in.af      = P2_BITS'(in_data.a * in_data.f);
      data_in.cf      = P2_BITS'(in_data.c * in_data.f);
      data_in.a       = in_data.a;
      data_in.c       = in_data.c;
      data_in.e       = in_data.e;
      data_in.f       = in_data.f;
      data_in.sgn_i1.neg  = i1[I1_BITS-1];
      data_in.sgn_i1.zero = (i1 == '0);
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/cct_triple_mul.sv]
// stage 2: triple products of the determinant, signs of 4*I2 and 4*K
// depends on cct_pkg
module cct_triple_mul import cct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  pair_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output triple_type out_data
);

   logic                      valid_ff;
   triple_type                data_ff;
   triple_type                data_in;
   logic signed [I2_BITS-1:0] i2;
   logic signed [K_BITS-1:0]  k;

   assign in_ready = !valid_ff || out_ready;

   // second products and the invariants I2 and K
   always_comb begin
      i2 = (I2_BITS'(in_data.ac) <<< 2) - I2_BITS'(in_data.bb);
      k  = (K_BITS'(in_data.af) <<< 2) + (K_BITS'(in_data.cf) <<< 2)
         - K_BITS'(in_data.dd) - K_BITS'(in_data.ee);
      data_in.acf = P3_BITS'(in_data.ac * in_data.f);
      data_in.bde = P3_BITS'(in_data.bd * in_data.e);
      data_in.aee = P3_BITS'(in_data.ee * in_data.a);
      data_in.cdd = P3_BITS'(in_data.dd * in_data.c);
      data_in.fbb = P3_BITS'(in_data.bb * in_data.f);
      data_in.sgn_i1      = in_data.sgn_i1;
      data_in.sgn_i2.neg  = i2[I2_BITS-1];
      data_in.sgn_i2.zero = (i2 == '0);
      data_in.sgn_k.neg   = k[K_BITS-1];
      data_in.sgn_k.zero  = (k == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/cct_partial.sv]
// stage 3: determinant terms folded into a positive and a negative partial sum
// depends on cct_pkg
module cct_partial import cct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  triple_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output part_type   out_data
);

   logic     valid_ff;
   part_type data_ff;
   part_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // 4acf + bde and ae^2 + cd^2 + fb^2
   always_comb begin
      data_in.p = (PSUM_BITS'(in_data.acf) <<< 2) + PSUM_BITS'(in_data.bde);
      data_in.q = QSUM_BITS'(in_data.aee) + QSUM_BITS'(in_data.cdd)
                + QSUM_BITS'(in_data.fbb);
      data_in.sgn_i1 = in_data.sgn_i1;
      data_in.sgn_i2 = in_data.sgn_i2;
      data_in.sgn_k  = in_data.sgn_k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/cct_classify.sv]
// stage 4: determinant sign, decision on curve kind, response register
// depends on cct_pkg and conic_type_classifier_top_defines.svh
`include "conic_type_classifier_top_defines.svh"

module cct_classify import cct_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  part_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output kind_type out_kind
);

   logic                      valid_ff;
   kind_type                  kind_ff;
   kind_type                  kind_in;
   logic signed [I3_BITS-1:0] i3;
   logic                      i3_neg;
   logic                      i3_zero;
   logic                      i2_pos;
   logic                      opposite;

   assign in_ready = !valid_ff || out_ready;

   // 4*I3 and its sign
   always_comb begin
      i3      = I3_BITS'(in_data.p) - I3_BITS'(in_data.q);
      i3_neg  = i3[I3_BITS-1];
      i3_zero = (i3 == '0);
   end

   // decision on the invariant signs
   always_comb begin
      i2_pos   = !in_data.sgn_i2.neg && !in_data.sgn_i2.zero;
      opposite = !in_data.sgn_i1.zero && !i3_zero && (in_data.sgn_i1.neg != i3_neg);
      if (i2_pos) begin
         if (opposite) begin
            kind_in = KIND_ELLIPSE;
         end else if (i3_zero) begin
            kind_in = KIND_POINT;
         end else begin
            kind_in = KIND_IMAG_ELLIPSE;
         end
      end else if (in_data.sgn_i2.neg) begin
         kind_in = i3_zero ? KIND_CROSS_LINES : KIND_HYPERBOLA;
      end else if (!i3_zero) begin
         kind_in = KIND_PARABOLA;
      end else if (in_data.sgn_k.zero) begin
         kind_in = KIND_LINE;
      end else if (in_data.sgn_k.neg) begin
         kind_in = KIND_PARALLEL_LINES;
      end else begin
         kind_in = KIND_IMAG_PARALLEL;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         kind_ff <= kind_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;

   // checks
   `CCT_ASSERT_IMPL(a_kind_in_range, clock, reset, valid_ff, kind_ff <= KIND_IMAG_PARALLEL, "kind code out of range")
   `CCT_ASSERT_NEXT(a_load_fills, clock, reset, in_valid && in_ready, valid_ff, "taken transaction lost")
   `CCT_ASSERT_NEXT(a_neg_i2_kinds, clock, reset, in_valid && in_ready && in_data.sgn_i2.neg, kind_ff == KIND_HYPERBOLA || kind_ff == KIND_CROSS_LINES, "negative I2 gave a wrong kind")
   `CCT_ASSERT_NEXT(a_zero_i2_kinds, clock, reset, in_valid && in_ready && in_data.sgn_i2.zero, kind_ff == KIND_PARABOLA || kind_ff == KIND_LINE || kind_ff == KIND_PARALLEL_LINES || kind_ff == KIND_IMAG_PARALLEL, "zero I2 gave a wrong kind")
   `CCT_ASSERT_IMPL(a_sign_flags, clock, reset, in_valid, !(in_data.sgn_i2.neg && in_data.sgn_i2.zero) && !(in_data.sgn_k.neg && in_data.sgn_k.zero), "sign flags both set")

endmodule

[rtl/conic_type_classifier_top.sv]
// channel    direction  payload
// req_ch     in         coef_xx coef_xy coef_yy coef_x coef_y coef_const
// rsp_ch     out        curve_kind
//
// four register stages: pair products, triple products, partial sums, decision
// one transaction per cycle while rsp_ch is not stalled
// synchronous active-high reset empties every stage; payload is not cleared
// each stage holds while its successor is full and stalled; bubbles are squeezed out
// depends on cct_pkg, cct_if and the four stage modules
module conic_type_classifier_top import cct_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cct_req_if.sink   req_ch,
   cct_rsp_if.source rsp_ch
);

   coef_type   coef;
   logic       s1_valid;
   logic       s1_ready;
   pair_type   s1_data;
   logic       s2_valid;
   logic       s2_ready;
   triple_type s2_data;
   logic       s3_valid;
   logic       s3_ready;
   part_type   s3_data;

   // request payload into the stage format
   always_comb begin
      coef.a = req_ch.coef_xx;
      coef.b = req_ch.coef_xy;
      coef.c = req_ch.coef_yy;
      coef.d = req_ch.coef_x;
      coef.e = req_ch.coef_y;
      coef.f = req_ch.coef_const;
   end

   cct_pair_mul u_pair (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (coef),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   cct_triple_mul u_triple (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   cct_partial u_partial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   cct_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_kind  (rsp_ch.curve_kind)
   );

endmodule
